// ===== rtl/sorted_array_table_engine_core_defines.svh =====
// Assertion macros used by the table engine checker.
`ifndef SORTED_ARRAY_TABLE_ENGINE_CORE_DEFINES_SVH
`define SORTED_ARRAY_TABLE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, quiet during reset.
`define SATE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("table engine check failed");

// Next-cycle implication, clocked on i_clk, quiet during reset.
`define SATE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("table engine check failed");

`endif

// ===== rtl/sate_pkg.sv =====
// Types and constants for the sorted array table engine.
package sate_pkg;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int ST_W  = 2;
    localparam int CNT_W = 5;

    typedef logic signed [VAL_W-1:0] t_word;
    typedef logic [OP_W-1:0]         t_op;
    typedef logic [ST_W-1:0]         t_status;

    localparam t_op OP_SORT_INS = 3'd0;
    localparam t_op OP_DELETE   = 3'd1;
    localparam t_op OP_UPDATE   = 3'd2;
    localparam t_op OP_POS_INS  = 3'd3;
    localparam t_op OP_READ     = 3'd4;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_EMPTY  = 2'd2;
    localparam t_status ST_BADPOS = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/sate_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sorted_array_table_engine_core.sv =====
// Sorted array table engine: top level with sequencer, fold unit and entry RAM.
// Keeps up to DEPTH signed words in one RAM with a single read and a single
// write port. Every request first scans the N stored entries one per cycle,
// folding min/max and doing delete compaction or update on the fly. Inserts
// then shift the N-at entries above the slot, one per cycle, and write the
// new word; an append writes it with no shift. The result register is then
// loaded, waiting while an earlier result is still held, and the sequencer
// returns to idle to take the next request. On an empty table the scan is
// skipped. The scan and shift move one entry at a time because the RAM has
// a single read port. A request is taken only while the sequencer is idle;
// the result register lets the next request in while a result is pending.
module sorted_array_table_engine_core
    import sate_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [OP_W-1:0]  i_op,
    input  t_word            i_value,
    input  logic [POS_W-1:0] i_position,
    input  t_word            i_new_value,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ST_W-1:0]  o_status,
    output logic [CNT_W-1:0] o_entry_count,
    output t_word            o_min_value,
    output t_word            o_max_value
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    t_state r_state, n_state;

    t_op     r_op, n_op;
    t_word   r_value, n_value;
    t_word   r_new, n_new;
    t_word   r_ins_val, n_ins_val;
    t_status r_status, n_status;
    logic    r_ins, n_ins;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_kept, n_kept;
    logic [CW-1:0] r_at, n_at;
    logic [CW-1:0] r_ri, n_ri;
    logic          r_iss_done, n_iss_done;
    logic          r_pv, n_pv;
    logic [AW-1:0] r_pi, n_pi;
    logic          r_found, n_found;
    logic          r_have, n_have;
    t_word         r_lo, n_lo;
    t_word         r_hi, n_hi;

    logic          r_ov;
    t_status       r_o_status;
    logic [CNT_W-1:0] r_o_count;
    t_word         r_o_min, r_o_max;

    logic          accept;
    logic          load_out;
    logic          last_scan;
    logic          last_shift;
    logic          sort_hit;
    logic          full, empty;
    t_status       acc_status;
    logic          acc_ins;
    logic [CW-1:0] acc_at;
    t_word         acc_ins_val;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_word         ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_word         rd_data;

    logic          fold_en;
    t_word         fold_x;

    sate_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Control outputs
    always_comb begin
        o_ready    = (r_state == S_IDLE);
        accept     = i_valid && o_ready;
        load_out   = (r_state == S_DONE) && (!r_ov || i_ready);
        last_scan  = r_pv && (CW'(r_pi) == r_count - CW'(1));
        last_shift = r_pv && (CW'(r_pi) == r_at);
        sort_hit   = r_pv && (r_op == OP_SORT_INS) && r_ins && !r_found
                     && (r_value < rd_data);
    end

    // Request decode
    always_comb begin
        full        = (r_count == CW'(DEPTH));
        empty       = (r_count == '0);
        acc_status  = ST_OK;
        acc_ins     = 1'b0;
        acc_at      = r_count;
        acc_ins_val = (i_op == OP_SORT_INS) ? i_value : i_new_value;
        case (i_op)
            OP_SORT_INS: begin
                if (full) begin
                    acc_status = ST_FULL;
                end else begin
                    acc_ins = 1'b1;
                end
            end
            OP_DELETE, OP_UPDATE: begin
                if (empty) begin
                    acc_status = ST_EMPTY;
                end
            end
            OP_POS_INS: begin
                if (full) begin
                    acc_status = ST_FULL;
                end else if (CMPW'(i_position) > CMPW'(r_count)) begin
                    acc_status = ST_BADPOS;
                end else begin
                    acc_ins = 1'b1;
                    acc_at  = CW'(i_position);
                end
            end
            default: begin
                if (empty) begin
                    acc_status = ST_EMPTY;
                end
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!empty) begin
                        n_state = S_SCAN;
                    end else if (acc_ins) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (last_scan) begin
                    if (!r_ins) begin
                        n_state = S_DONE;
                    end else if (n_at == r_count) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (last_shift) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM access and shared min/max fold unit
    always_comb begin
        n_op       = r_op;
        n_value    = r_value;
        n_new      = r_new;
        n_ins_val  = r_ins_val;
        n_status   = r_status;
        n_ins      = r_ins;
        n_count    = r_count;
        n_kept     = r_kept;
        n_at       = r_at;
        n_ri       = r_ri;
        n_iss_done = r_iss_done;
        n_pv       = r_pv;
        n_pi       = r_pi;
        n_found    = r_found;
        n_have     = r_have;
        n_lo       = r_lo;
        n_hi       = r_hi;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = r_ins_val;
        ram_raddr  = '0;
        fold_en    = 1'b0;
        fold_x     = rd_data;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = i_op;
                    n_value   = i_value;
                    n_new     = i_new_value;
                    n_ins_val = acc_ins_val;
                    n_status  = acc_status;
                    n_ins     = acc_ins;
                    n_at      = acc_at;
                    n_ri      = '0;
                    n_pv      = 1'b0;
                    n_found   = 1'b0;
                    n_kept    = '0;
                    n_have    = acc_ins;
                    n_lo      = acc_ins_val;
                    n_hi      = acc_ins_val;
                end
            end
            S_SCAN: begin
                if (r_ri != r_count) begin
                    ram_raddr = r_ri[AW-1:0];
                    n_ri      = r_ri + CW'(1);
                    n_pi      = r_ri[AW-1:0];
                    n_pv      = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    fold_en = 1'b1;
                    case (r_op)
                        OP_SORT_INS: begin
                            if (sort_hit) begin
                                n_at    = CW'(r_pi);
                                n_found = 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (rd_data != r_value) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_kept[AW-1:0];
                                ram_wdata = rd_data;
                                n_kept    = r_kept + CW'(1);
                            end else begin
                                fold_en = 1'b0;
                            end
                        end
                        OP_UPDATE: begin
                            if (!r_found && (rd_data == r_value)) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_pi;
                                ram_wdata = r_new;
                                n_found   = 1'b1;
                                fold_x    = r_new;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (last_scan) begin
                        if (r_op == OP_DELETE) begin
                            n_count = n_kept;
                        end
                        n_ri       = r_count - CW'(1);
                        n_iss_done = 1'b0;
                    end
                end
            end
            S_SHIFT: begin
                if (!r_iss_done) begin
                    ram_raddr  = r_ri[AW-1:0];
                    n_ri       = r_ri - CW'(1);
                    n_pi       = r_ri[AW-1:0];
                    n_pv       = 1'b1;
                    n_iss_done = (r_ri == r_at);
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pi + AW'(1);
                    ram_wdata = rd_data;
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_at[AW-1:0];
                ram_wdata = r_ins_val;
                n_count   = r_count + CW'(1);
                n_pv      = 1'b0;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase

        if (fold_en) begin
            if (!r_have || (fold_x < r_lo)) begin
                n_lo = fold_x;
            end
            if (!r_have || (fold_x > r_hi)) begin
                n_hi = fold_x;
            end
            n_have = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_value    <= n_value;
        r_new      <= n_new;
        r_ins_val  <= n_ins_val;
        r_status   <= n_status;
        r_ins      <= n_ins;
        r_kept     <= n_kept;
        r_at       <= n_at;
        r_ri       <= n_ri;
        r_iss_done <= n_iss_done;
        r_pi       <= n_pi;
        r_found    <= n_found;
        r_have     <= n_have;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_status <= r_status;
            r_o_count  <= CNT_W'(r_count);
            r_o_min    <= r_have ? r_lo : '0;
            r_o_max    <= r_have ? r_hi : '0;
        end
    end

    assign o_valid       = r_ov;
    assign o_status      = r_o_status;
    assign o_entry_count = r_o_count;
    assign o_min_value   = r_o_min;
    assign o_max_value   = r_o_max;

endmodule

// ===== rtl/sate_chk.sv =====
// Port-level checker for the table engine, bound to the top level.
`include "sorted_array_table_engine_core_defines.svh"

module sate_chk
    import sate_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic [OP_W-1:0]  i_op,
    input t_word            i_value,
    input logic [POS_W-1:0] i_position,
    input t_word            i_new_value,
    input logic             o_valid,
    input logic             i_ready,
    input logic [ST_W-1:0]  o_status,
    input logic [CNT_W-1:0] o_entry_count,
    input t_word            o_min_value,
    input t_word            o_max_value
);

    // stalled result holds
    `SATE_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_entry_count) && $stable(o_min_value) && $stable(o_max_value))

    // busy after taking a request
    `SATE_ASSERT_NXT(a_busy_after_req, i_valid && o_ready, !o_ready)

    `SATE_ASSERT_IMP(a_min_le_max, o_valid, o_min_value <= o_max_value)

    `SATE_ASSERT_IMP(a_full_count, o_valid && (o_status == ST_FULL), o_entry_count == CNT_W'(DEPTH))

    `SATE_ASSERT_IMP(a_empty_count, o_valid && (o_status == ST_EMPTY), (o_entry_count == '0) && (o_min_value == '0) && (o_max_value == '0))

endmodule

bind sorted_array_table_engine_core sate_chk #(.DEPTH(DEPTH)) u_sate_chk (.*);
